/* design/ps2mt_pkg.sv */
// ps2mt_pkg: shared types and constants for the ps/2 mouse packet tracker
// used by ps2mt_front, ps2mt_queue, ps2mt_back and ps2_mouse_packet_tracker_unit
`timescale 1ns / 1ps

package ps2mt_pkg;

    // configuration register map
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_BITS-1:0]     WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0]     HEIGHT_RESET = 13'd480;

    // header byte layout
    localparam int SYNC_BIT_POS = 3;
    localparam int NUM_BUTTONS  = 3;
    localparam logic [NUM_BUTTONS-1:0] BTN_MASK_LEFT   = 3'h1;
    localparam logic [NUM_BUTTONS-1:0] BTN_MASK_RIGHT  = 3'h2;
    localparam logic [NUM_BUTTONS-1:0] BTN_MASK_MIDDLE = 3'h4;

    // result codes
    typedef enum logic [1:0] {
        EVT_DOWN = 2'd0,
        EVT_UP   = 2'd1,
        EVT_MOVE = 2'd2
    } t_evt_kind;

    typedef enum logic [1:0] {
        BTN_ID_NONE   = 2'd0,
        BTN_ID_LEFT   = 2'd1,
        BTN_ID_RIGHT  = 2'd2,
        BTN_ID_MIDDLE = 2'd3
    } t_btn_id;

    // which byte of the packet comes next
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } t_phase;

    // per-packet event plan handed from front to back
    typedef struct packed {
        logic                   move;
        logic [NUM_BUTTONS-1:0] cur;
        logic [NUM_BUTTONS-1:0] changed;
    } t_pkt_flags;

    localparam int FLAGS_BITS = $bits(t_pkt_flags);

    // packet queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;

endpackage

/* design/ps2_mouse_packet_tracker_unit.sv */
// ps2_mouse_packet_tracker_unit: top level of the ps/2 mouse packet tracker
// depends on ps2mt_pkg, ps2mt_front, ps2mt_queue and ps2mt_back
`timescale 1ns / 1ps

// Usage
//   slave stream: one raw mouse byte per beat on i_s_tdata. Headers without
//   the sync bit are dropped until a packet boundary is found again.
//   master stream: one event per beat; tuser carries the kind and button,
//   tdata the cursor position and the packet deltas, tlast marks the final
//   event of a packet. A packet gives up to three button events and a move.
//   config channel: index 0 screen width, index 1 screen height; write only
//   while no packet is in flight. Writes complete in the cycle they appear.
//   Flow: after the third byte is accepted, the first event of a packet passes
//   the packet queue, the back end's record register and the output register;
//   the rest follow one per cycle while the receiver is ready. Bytes are taken
//   every cycle; only the third byte of a packet waits for room in the two-entry
//   packet queue. The back end loads a whole packet before emitting its events.
//   Reset: phase, cursor and button history clear, width 640, height 480.
//   A stalled receiver holds the current event; the queue absorbs two more
//   packets, after which the third byte of the next packet is held off.
module ps2_mouse_packet_tracker_unit #(
    parameter int POS_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input bytes; tdata: rx_byte[7:0]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,
    // events; tdata: pos_x, pos_y, vel_x[7:0], vel_y[7:0], zero fill
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [((2*POS_BITS+16+7)/8)*8-1:0] o_m_tdata,
    // tuser: event_kind[1:0], button_id[3:2]
    output logic [3:0]                         o_m_tuser,
    output logic                               o_m_tlast,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ps2mt_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ps2mt_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import ps2mt_pkg::*;

    localparam int TDATA_W  = ((2 * POS_BITS + 16 + 7) / 8) * 8;
    localparam int REC_BITS = FLAGS_BITS + 2 * POS_BITS + 16;

    logic                q_push;
    logic [REC_BITS-1:0] q_push_data;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    logic [REC_BITS-1:0] q_pop_data;

    assign o_cfg_ready = 1'b1;

    // byte sync, cursor and event planning
    ps2mt_front #(
        .POS_BITS (POS_BITS),
        .REC_BITS (REC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_s_tvalid),
        .o_byte_ready (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_push_data)
    );

    // packet queue
    ps2mt_queue #(
        .WIDTH (REC_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_pop_data  (q_pop_data)
    );

    // event emission
    ps2mt_back #(
        .POS_BITS (POS_BITS),
        .REC_BITS (REC_BITS),
        .TDATA_W  (TDATA_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_pop_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_user    (o_m_tuser),
        .o_last    (o_m_tlast)
    );

endmodule

/* design/ps2mt_queue.sv */
// ps2mt_queue: two-entry packet queue between the front and back parts
// depends on ps2mt_pkg for depth constants
`timescale 1ns / 1ps

module ps2mt_queue #(
    parameter int WIDTH = 47
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_pop_data
);
    import ps2mt_pkg::*;

    logic [WIDTH-1:0]     r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full     = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/ps2mt_front.sv */
// ps2mt_front: byte sync, packet assembly, cursor update and event planning
// depends on ps2mt_pkg; pushes one record per eventful packet into ps2mt_queue
`timescale 1ns / 1ps

module ps2mt_front #(
    parameter int POS_BITS = 12,
    parameter int REC_BITS = 47
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // byte input
    input  logic                    i_byte_valid,
    output logic                    o_byte_ready,
    input  logic [7:0]              i_byte,
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic [ps2mt_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ps2mt_pkg::CFG_BITS-1:0]     i_cfg_data,
    // queue side
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output logic [REC_BITS-1:0]     o_q_data
);
    import ps2mt_pkg::*;

    // signed working width that holds cursor, delta and limit
    localparam int SW = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 2;
    localparam logic [SW-1:0] PMAX = SW'((1 << POS_BITS) - 1);

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [7:0]             r_header;
    logic [7:0]             r_dx;
    logic [POS_BITS-1:0]    r_cur_x;
    logic [POS_BITS-1:0]    r_cur_y;
    logic [POS_BITS-1:0]    r_lim_x;
    logic [POS_BITS-1:0]    r_lim_y;
    logic [NUM_BUTTONS-1:0] r_prev_btn;

    logic                   accept;
    logic                   is_header;
    logic                   is_dx;
    logic                   is_dy;
    logic signed [7:0]      dx_s;
    logic signed [7:0]      dy_s;
    logic [POS_BITS-1:0]    new_x;
    logic [POS_BITS-1:0]    new_y;
    t_pkt_flags             flags;

    // clamp limit from a screen size: zero acts as one, saturate to position range
    function automatic logic [POS_BITS-1:0] size_to_lim(input logic [CFG_BITS-1:0] size);
        logic [SW-1:0] l;
        l = (size == '0) ? '0 : SW'(size) - SW'(1);
        if (l > PMAX) begin
            l = PMAX;
        end
        return l[POS_BITS-1:0];
    endfunction

    // move one axis by a signed delta and clamp to [0, lim]
    function automatic logic [POS_BITS-1:0] step_axis(
        input logic [POS_BITS-1:0] pos,
        input logic signed [SW-1:0] delta,
        input logic [POS_BITS-1:0] lim
    );
        logic signed [SW-1:0] v;
        logic [POS_BITS-1:0]  r;
        v = $signed(SW'(pos)) + delta;
        if (v[SW-1]) begin
            r = '0;
        end else if (v > $signed(SW'(lim))) begin
            r = lim;
        end else begin
            r = v[POS_BITS-1:0];
        end
        return r;
    endfunction

    assign is_dy        = (r_phase == PH_DY);
    assign is_dx        = (r_phase == PH_DX);
    assign is_header    = !is_dy && !is_dx;
    assign o_byte_ready = !is_dy || !i_q_full;
    assign accept       = i_byte_valid && o_byte_ready;

    // packet arithmetic on the third byte
    assign dx_s  = $signed(r_dx);
    assign dy_s  = $signed(i_byte);
    assign new_x = step_axis(r_cur_x, SW'(dx_s), r_lim_x);
    assign new_y = step_axis(r_cur_y, -SW'(dy_s), r_lim_y);

    always_comb begin
        flags.cur     = r_header[NUM_BUTTONS-1:0]
                        & (BTN_MASK_LEFT | BTN_MASK_RIGHT | BTN_MASK_MIDDLE);
        flags.changed = flags.cur ^ r_prev_btn;
        flags.move    = (r_dx != 8'd0) || (i_byte != 8'd0);
    end

    assign o_q_push = accept && is_dy && ((flags.changed != '0) || flags.move);
    assign o_q_data = REC_BITS'({flags, i_byte, r_dx, new_y, new_x});

    // byte phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_DX:   n_phase = PH_DY;
                PH_DY:   n_phase = PH_HEADER;
                default: n_phase = i_byte[SYNC_BIT_POS] ? PH_DX : PH_HEADER;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else begin
            r_phase <= n_phase;
        end
    end

    // packet bytes, cursor and button history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= '0;
            r_dx       <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_prev_btn <= '0;
        end else if (accept) begin
            if (is_header && i_byte[SYNC_BIT_POS]) begin
                r_header <= i_byte;
            end
            if (is_dx) begin
                r_dx <= i_byte;
            end
            if (is_dy) begin
                r_cur_x    <= new_x;
                r_cur_y    <= new_y;
                r_prev_btn <= flags.cur;
            end
        end
    end

    // screen limits, kept as clamp values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_x <= size_to_lim(WIDTH_RESET);
            r_lim_y <= size_to_lim(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_SCREEN_WIDTH) begin
                r_lim_x <= size_to_lim(i_cfg_data);
            end
            if (i_cfg_index == REG_SCREEN_HEIGHT) begin
                r_lim_y <= size_to_lim(i_cfg_data);
            end
        end
    end

endmodule

/* design/ps2mt_back.sv */
// ps2mt_back: emits a queued packet record's events one per cycle unless stalled
// depends on ps2mt_pkg; reads from ps2mt_queue, drives the output register
`timescale 1ns / 1ps

module ps2mt_back #(
    parameter int POS_BITS = 12,
    parameter int REC_BITS = 47,
    parameter int TDATA_W  = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // queue side
    input  logic                i_q_empty,
    input  logic [REC_BITS-1:0] i_q_data,
    output logic                o_q_pop,
    // result stream
    output logic                o_valid,
    input  logic                i_ready,
    output logic [TDATA_W-1:0]  o_data,
    output logic [3:0]          o_user,
    output logic                o_last
);
    import ps2mt_pkg::*;

    localparam int DATA_BITS = 2 * POS_BITS + 16;

    logic                   r_busy;
    t_pkt_flags             r_flags;
    logic [DATA_BITS-1:0]   r_payload;
    logic [NUM_BUTTONS-1:0] r_pend;
    logic                   r_pend_move;

    logic                   r_m_valid;
    logic [TDATA_W-1:0]     r_m_data;
    logic [3:0]             r_m_user;
    logic                   r_m_last;

    logic                   can_emit;
    logic                   emit;
    t_evt_kind              ev_kind;
    t_btn_id                ev_id;
    logic [NUM_BUTTONS-1:0] n_pend;
    logic                   n_pend_move;
    logic                   ev_last;
    t_pkt_flags             q_flags;

    assign q_flags  = t_pkt_flags'(i_q_data[DATA_BITS +: FLAGS_BITS]);
    assign can_emit = !r_m_valid || i_ready;
    assign emit     = r_busy && can_emit;
    assign o_q_pop  = !r_busy && !i_q_empty;

    // pick the next pending event: buttons in the order left, right, middle, then motion
    always_comb begin
        n_pend      = r_pend;
        n_pend_move = r_pend_move;
        ev_kind     = EVT_MOVE;
        ev_id       = BTN_ID_NONE;
        priority if (r_pend[0]) begin
            ev_kind   = r_flags.cur[0] ? EVT_DOWN : EVT_UP;
            ev_id     = BTN_ID_LEFT;
            n_pend[0] = 1'b0;
        end else if (r_pend[1]) begin
            ev_kind   = r_flags.cur[1] ? EVT_DOWN : EVT_UP;
            ev_id     = BTN_ID_RIGHT;
            n_pend[1] = 1'b0;
        end else if (r_pend[2]) begin
            ev_kind   = r_flags.cur[2] ? EVT_DOWN : EVT_UP;
            ev_id     = BTN_ID_MIDDLE;
            n_pend[2] = 1'b0;
        end else begin
            n_pend_move = 1'b0;
        end
        ev_last = (n_pend == '0) && !n_pend_move;
    end

    // current packet record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= '0;
            r_pend_move <= 1'b0;
        end else if (o_q_pop) begin
            r_busy      <= 1'b1;
            r_pend      <= q_flags.changed;
            r_pend_move <= q_flags.move;
        end else if (emit) begin
            r_busy      <= !ev_last;
            r_pend      <= n_pend;
            r_pend_move <= n_pend_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_flags   <= q_flags;
            r_payload <= i_q_data[DATA_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (i_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_data <= TDATA_W'(r_payload);
            r_m_user <= {ev_id, ev_kind};
            r_m_last <= ev_last;
        end
    end

    assign o_valid = r_m_valid;
    assign o_data  = r_m_data;
    assign o_user  = r_m_user;
    assign o_last  = r_m_last;

endmodule
